### hdl/tndq_pkg.sv
// Shared types, constants and codes of the transit-node distance query unit.
// Used by every module under hdl; depends on nothing.
`default_nettype none
package tndq_pkg;

	localparam int TRANSIT_NODES = 64;
	localparam int GRAPH_NODES   = 1024;
	localparam int MAX_ACCESS    = 16;
	localparam int REGIONS       = 32;

	localparam int DIST_W  = 32;
	localparam int FLAG_W  = 32;
	localparam int REG_W   = 5;
	localparam int TI_W    = $clog2(TRANSIT_NODES);
	localparam int NODE_W  = $clog2(GRAPH_NODES);
	localparam int TAB_DEPTH = TRANSIT_NODES * TRANSIT_NODES;
	localparam int TAB_AW  = $clog2(TAB_DEPTH);
	localparam int AC_W    = (MAX_ACCESS > 1) ? $clog2(MAX_ACCESS) : 1;
	localparam int CNT_W   = $clog2(MAX_ACCESS + 1);
	localparam int PAIR_W  = DIST_W + 1;
	localparam int SUM_W   = DIST_W + 2;

	localparam logic [DIST_W-1:0] DIST_INF = '1;

	typedef enum logic [2:0] {
		CMD_TAB_WR   = 3'd0,
		CMD_MAP_WR   = 3'd1,
		CMD_PUSH_FWD = 3'd2,
		CMD_PUSH_BWD = 3'd3,
		CMD_QUERY    = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_XLATE,
		ST_WALK,
		ST_DRAIN,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [9:0]  node_id;
		logic [5:0]  row_index;
		logic [5:0]  col_index;
		logic [31:0] distance;
		logic [31:0] region_flags;
		logic [4:0]  source_region;
		logic [4:0]  target_region;
	} in_t;

	typedef struct packed {
		logic [31:0] shortest;
		logic        found;
	} out_t;

	typedef struct packed {
		logic            init;
		logic            xlate_valid;
		logic [AC_W-1:0] xlate_idx;
		logic            walk_valid;
		logic [AC_W-1:0] fwd_idx;
		logic [AC_W-1:0] bwd_idx;
		logic            clear;
	} ctrl_t;

	typedef struct packed {
		logic [DIST_W-1:0] fwd_dist;
		logic [FLAG_W-1:0] fwd_flags;
		logic [TI_W-1:0]   fwd_ti;
		logic [DIST_W-1:0] bwd_dist;
		logic [FLAG_W-1:0] bwd_flags;
		logic [TI_W-1:0]   bwd_ti;
	} pair_rd_t;

endpackage
`default_nettype wire

### hdl/tndq_store.sv
// Transit distance table and node-to-transit map, both on-chip memories.
// Depends on tndq_pkg.
`default_nettype none
module tndq_store (
	input  wire logic                         clk,
	input  wire logic                         accept,
	input  wire tndq_pkg::in_t                item,
	input  wire logic [tndq_pkg::NODE_W-1:0]  map_raddr_f,
	input  wire logic [tndq_pkg::NODE_W-1:0]  map_raddr_b,
	input  wire logic [tndq_pkg::TAB_AW-1:0]  tab_raddr,
	output logic      [tndq_pkg::TI_W-1:0]    map_rdata_f,
	output logic      [tndq_pkg::TI_W-1:0]    map_rdata_b,
	output logic      [tndq_pkg::DIST_W-1:0]  tab_rdata
);

	logic [tndq_pkg::DIST_W-1:0] tab_mem [tndq_pkg::TAB_DEPTH];
	logic [tndq_pkg::TI_W-1:0]   map_mem [tndq_pkg::GRAPH_NODES];

	logic                        tab_we;
	logic                        map_we;
	logic [tndq_pkg::TAB_AW-1:0] tab_waddr;

	always_comb begin
		tab_we = accept && (item.cmd == tndq_pkg::CMD_TAB_WR)
			&& (32'(item.row_index) < tndq_pkg::TRANSIT_NODES)
			&& (32'(item.col_index) < tndq_pkg::TRANSIT_NODES);
		map_we = accept && (item.cmd == tndq_pkg::CMD_MAP_WR)
			&& (32'(item.node_id) < tndq_pkg::GRAPH_NODES)
			&& (32'(item.row_index) < tndq_pkg::TRANSIT_NODES);
		tab_waddr = tndq_pkg::TAB_AW'(item.row_index)
			* tndq_pkg::TAB_AW'(tndq_pkg::TRANSIT_NODES)
			+ tndq_pkg::TAB_AW'(item.col_index);
	end

	always_ff @(posedge clk) begin
		if (tab_we) begin
			tab_mem[tab_waddr] <= item.distance;
		end
		tab_rdata <= tab_mem[tab_raddr];
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[tndq_pkg::NODE_W'(item.node_id)] <= tndq_pkg::TI_W'(item.row_index);
		end
		map_rdata_f <= map_mem[map_raddr_f];
		map_rdata_b <= map_mem[map_raddr_b];
	end

endmodule
`default_nettype wire

### hdl/tndq_lists.sv
// Forward and backward access lists with their fill counts and the transit
// index of each entry, filled from the map at query start. Depends on tndq_pkg.
`default_nettype none
module tndq_lists (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire tndq_pkg::in_t                item,
	input  wire tndq_pkg::ctrl_t              ctrl,
	input  wire logic [tndq_pkg::TI_W-1:0]    map_rdata_f,
	input  wire logic [tndq_pkg::TI_W-1:0]    map_rdata_b,
	output logic      [tndq_pkg::NODE_W-1:0]  map_raddr_f,
	output logic      [tndq_pkg::NODE_W-1:0]  map_raddr_b,
	output logic      [tndq_pkg::CNT_W-1:0]   fwd_count,
	output logic      [tndq_pkg::CNT_W-1:0]   bwd_count,
	output tndq_pkg::pair_rd_t                pair_rd
);

	logic [tndq_pkg::NODE_W-1:0] fwd_node_q  [tndq_pkg::MAX_ACCESS];
	logic [tndq_pkg::DIST_W-1:0] fwd_dist_q  [tndq_pkg::MAX_ACCESS];
	logic [tndq_pkg::FLAG_W-1:0] fwd_flags_q [tndq_pkg::MAX_ACCESS];
	logic [tndq_pkg::TI_W-1:0]   fwd_ti_q    [tndq_pkg::MAX_ACCESS];
	logic [tndq_pkg::NODE_W-1:0] bwd_node_q  [tndq_pkg::MAX_ACCESS];
	logic [tndq_pkg::DIST_W-1:0] bwd_dist_q  [tndq_pkg::MAX_ACCESS];
	logic [tndq_pkg::FLAG_W-1:0] bwd_flags_q [tndq_pkg::MAX_ACCESS];
	logic [tndq_pkg::TI_W-1:0]   bwd_ti_q    [tndq_pkg::MAX_ACCESS];

	logic [tndq_pkg::CNT_W-1:0] fwd_count_q;
	logic [tndq_pkg::CNT_W-1:0] bwd_count_q;
	logic                       xlate_valid_s1;
	logic [tndq_pkg::AC_W-1:0]  xlate_idx_s1;
	logic                       node_ok;
	logic                       push_fwd;
	logic                       push_bwd;

	always_comb begin
		node_ok  = 32'(item.node_id) < tndq_pkg::GRAPH_NODES;
		push_fwd = accept && (item.cmd == tndq_pkg::CMD_PUSH_FWD) && node_ok
			&& (32'(fwd_count_q) < tndq_pkg::MAX_ACCESS);
		push_bwd = accept && (item.cmd == tndq_pkg::CMD_PUSH_BWD) && node_ok
			&& (32'(bwd_count_q) < tndq_pkg::MAX_ACCESS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_count_q    <= '0;
			bwd_count_q    <= '0;
			xlate_valid_s1 <= 1'b0;
		end else begin
			xlate_valid_s1 <= ctrl.xlate_valid;
			if (ctrl.clear) begin
				fwd_count_q <= '0;
				bwd_count_q <= '0;
			end else begin
				if (push_fwd) begin
					fwd_count_q <= fwd_count_q + tndq_pkg::CNT_W'(1);
				end
				if (push_bwd) begin
					bwd_count_q <= bwd_count_q + tndq_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		xlate_idx_s1 <= ctrl.xlate_idx;
		if (push_fwd) begin
			fwd_node_q[fwd_count_q[tndq_pkg::AC_W-1:0]]  <= tndq_pkg::NODE_W'(item.node_id);
			fwd_dist_q[fwd_count_q[tndq_pkg::AC_W-1:0]]  <= item.distance;
			fwd_flags_q[fwd_count_q[tndq_pkg::AC_W-1:0]] <= item.region_flags;
		end
		if (push_bwd) begin
			bwd_node_q[bwd_count_q[tndq_pkg::AC_W-1:0]]  <= tndq_pkg::NODE_W'(item.node_id);
			bwd_dist_q[bwd_count_q[tndq_pkg::AC_W-1:0]]  <= item.distance;
			bwd_flags_q[bwd_count_q[tndq_pkg::AC_W-1:0]] <= item.region_flags;
		end
		// map data arrives in the cycle after the address went out
		if (xlate_valid_s1) begin
			fwd_ti_q[xlate_idx_s1] <= map_rdata_f;
			bwd_ti_q[xlate_idx_s1] <= map_rdata_b;
		end
	end

	always_comb begin
		map_raddr_f       = fwd_node_q[ctrl.xlate_idx];
		map_raddr_b       = bwd_node_q[ctrl.xlate_idx];
		fwd_count         = fwd_count_q;
		bwd_count         = bwd_count_q;
		pair_rd.fwd_dist  = fwd_dist_q[ctrl.fwd_idx];
		pair_rd.fwd_flags = fwd_flags_q[ctrl.fwd_idx];
		pair_rd.fwd_ti    = fwd_ti_q[ctrl.fwd_idx];
		pair_rd.bwd_dist  = bwd_dist_q[ctrl.bwd_idx];
		pair_rd.bwd_flags = bwd_flags_q[ctrl.bwd_idx];
		pair_rd.bwd_ti    = bwd_ti_q[ctrl.bwd_idx];
	end

endmodule
`default_nettype wire

### hdl/tndq_accum.sv
// Shared pair unit: region test, table address, wide sum and running minimum.
// Depends on tndq_pkg; table data comes from tndq_store in the cycle after the address.
`default_nettype none
module tndq_accum (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tndq_pkg::ctrl_t              ctrl,
	input  wire logic [tndq_pkg::REG_W-1:0]   source_region,
	input  wire logic [tndq_pkg::REG_W-1:0]   target_region,
	input  wire tndq_pkg::pair_rd_t           pair_rd,
	input  wire logic [tndq_pkg::DIST_W-1:0]  tab_rdata,
	output logic      [tndq_pkg::TAB_AW-1:0]  tab_raddr,
	output logic                              pipe_busy,
	output tndq_pkg::out_t                    result
);

	logic [tndq_pkg::REG_W-1:0]  sreg_q;
	logic [tndq_pkg::REG_W-1:0]  treg_q;
	logic                        valid_s1;
	logic                        admit_s1;
	logic [tndq_pkg::PAIR_W-1:0] dsum_s1;
	logic                        hit_s2;
	logic [tndq_pkg::SUM_W-1:0]  sum_s2;
	logic [tndq_pkg::DIST_W-1:0] best_q;
	logic                        found_q;
	logic                        admit;

	always_comb begin
		admit = (32'(treg_q) < tndq_pkg::REGIONS) && pair_rd.fwd_flags[treg_q]
			&& (32'(sreg_q) < tndq_pkg::REGIONS) && pair_rd.bwd_flags[sreg_q];
		tab_raddr = tndq_pkg::TAB_AW'(pair_rd.fwd_ti)
			* tndq_pkg::TAB_AW'(tndq_pkg::TRANSIT_NODES)
			+ tndq_pkg::TAB_AW'(pair_rd.bwd_ti);
		pipe_busy       = valid_s1 || hit_s2;
		result.shortest = best_q;
		result.found    = found_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			sreg_q <= source_region;
			treg_q <= target_region;
		end
		admit_s1 <= admit;
		dsum_s1  <= tndq_pkg::PAIR_W'(pair_rd.fwd_dist) + tndq_pkg::PAIR_W'(pair_rd.bwd_dist);
		sum_s2   <= tndq_pkg::SUM_W'(dsum_s1) + tndq_pkg::SUM_W'(tab_rdata);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			hit_s2   <= 1'b0;
			best_q   <= tndq_pkg::DIST_INF;
			found_q  <= 1'b0;
		end else begin
			valid_s1 <= ctrl.walk_valid;
			// drop pairs whose table entry marks the transit pair unreachable
			hit_s2   <= valid_s1 && admit_s1 && (tab_rdata != tndq_pkg::DIST_INF);
			if (ctrl.init) begin
				best_q  <= tndq_pkg::DIST_INF;
				found_q <= 1'b0;
			end else if (hit_s2) begin
				found_q <= 1'b1;
				if (sum_s2 < tndq_pkg::SUM_W'(best_q)) begin
					best_q <= sum_s2[tndq_pkg::DIST_W-1:0];
				end
			end
		end
	end

endmodule
`default_nettype wire

### hdl/tndq_seq.sv
// Query sequencer: map translation sweep, pair walk, drain and result strobe.
// Depends on tndq_pkg.
`default_nettype none
module tndq_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire tndq_pkg::in_t               item,
	input  wire logic [tndq_pkg::CNT_W-1:0]  fwd_count,
	input  wire logic [tndq_pkg::CNT_W-1:0]  bwd_count,
	input  wire logic                        pipe_busy,
	output logic                             busy,
	output tndq_pkg::ctrl_t                  ctrl
);

	tndq_pkg::st_t state_q;
	tndq_pkg::st_t state_d;

	logic [tndq_pkg::CNT_W-1:0] k_q;
	logic [tndq_pkg::AC_W-1:0]  i_q;
	logic [tndq_pkg::AC_W-1:0]  j_q;
	logic                       query_acc;
	logic                       xlate_end;
	logic                       i_last;
	logic                       j_last;
	logic                       lists_full;

	always_comb begin
		query_acc  = start && (state_q == tndq_pkg::ST_IDLE)
			&& (item.cmd == tndq_pkg::CMD_QUERY);
		xlate_end  = 32'(k_q) == tndq_pkg::MAX_ACCESS;
		i_last     = (tndq_pkg::CNT_W'(i_q) + tndq_pkg::CNT_W'(1)) == fwd_count;
		j_last     = (tndq_pkg::CNT_W'(j_q) + tndq_pkg::CNT_W'(1)) == bwd_count;
		lists_full = (fwd_count != '0) && (bwd_count != '0);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tndq_pkg::ST_IDLE: begin
				if (query_acc) state_d = tndq_pkg::ST_XLATE;
			end
			tndq_pkg::ST_XLATE: begin
				if (xlate_end) state_d = lists_full ? tndq_pkg::ST_WALK : tndq_pkg::ST_DRAIN;
			end
			tndq_pkg::ST_WALK: begin
				if (i_last && j_last) state_d = tndq_pkg::ST_DRAIN;
			end
			tndq_pkg::ST_DRAIN: begin
				if (!pipe_busy) state_d = tndq_pkg::ST_DONE;
			end
			tndq_pkg::ST_DONE: begin
				state_d = tndq_pkg::ST_IDLE;
			end
			default: begin
				state_d = tndq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy             = state_q != tndq_pkg::ST_IDLE;
		ctrl.init        = query_acc;
		ctrl.xlate_valid = (state_q == tndq_pkg::ST_XLATE) && !xlate_end;
		ctrl.xlate_idx   = k_q[tndq_pkg::AC_W-1:0];
		ctrl.walk_valid  = state_q == tndq_pkg::ST_WALK;
		ctrl.fwd_idx     = i_q;
		ctrl.bwd_idx     = j_q;
		ctrl.clear       = state_q == tndq_pkg::ST_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tndq_pkg::ST_IDLE;
			k_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				tndq_pkg::ST_XLATE: begin
					k_q <= k_q + tndq_pkg::CNT_W'(1);
					i_q <= '0;
					j_q <= '0;
				end
				tndq_pkg::ST_WALK: begin
					// advance inner index, wrap into the next forward entry
					if (j_last) begin
						j_q <= '0;
						i_q <= i_q + tndq_pkg::AC_W'(1);
					end else begin
						j_q <= j_q + tndq_pkg::AC_W'(1);
					end
				end
				default: begin
					k_q <= '0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/transit_node_distance_query_unit.sv
// Transit-node distance query: writes and pushes leave busy low.
// A query holds busy through a map sweep of all MAX_ACCESS list slots, a walk of every
// forward and backward pair, one pair per cycle on the table read port (no walk when
// a list is empty), and a drain of the pair pipeline; the result strobe is the last
// busy cycle. Reset clears the list counts and the sequencer; table and map contents
// stay undefined until written. Results never stall.
`default_nettype none
module transit_node_distance_query_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire tndq_pkg::in_t  item,
	output tndq_pkg::out_t      result,
	output logic                result_strobe
);

	tndq_pkg::ctrl_t    ctrl;
	tndq_pkg::pair_rd_t pair_rd;

	logic                        accept;
	logic [tndq_pkg::NODE_W-1:0] map_raddr_f;
	logic [tndq_pkg::NODE_W-1:0] map_raddr_b;
	logic [tndq_pkg::TI_W-1:0]   map_rdata_f;
	logic [tndq_pkg::TI_W-1:0]   map_rdata_b;
	logic [tndq_pkg::TAB_AW-1:0] tab_raddr;
	logic [tndq_pkg::DIST_W-1:0] tab_rdata;
	logic [tndq_pkg::CNT_W-1:0]  fwd_count;
	logic [tndq_pkg::CNT_W-1:0]  bwd_count;
	logic                        pipe_busy;

	assign accept        = start && !busy;
	assign result_strobe = ctrl.clear;

	tndq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.fwd_count (fwd_count),
		.bwd_count (bwd_count),
		.pipe_busy (pipe_busy),
		.busy      (busy),
		.ctrl      (ctrl)
	);

	tndq_store u_store (
		.clk         (clk),
		.accept      (accept),
		.item        (item),
		.map_raddr_f (map_raddr_f),
		.map_raddr_b (map_raddr_b),
		.tab_raddr   (tab_raddr),
		.map_rdata_f (map_rdata_f),
		.map_rdata_b (map_rdata_b),
		.tab_rdata   (tab_rdata)
	);

	tndq_lists u_lists (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.item        (item),
		.ctrl        (ctrl),
		.map_rdata_f (map_rdata_f),
		.map_rdata_b (map_rdata_b),
		.map_raddr_f (map_raddr_f),
		.map_raddr_b (map_raddr_b),
		.fwd_count   (fwd_count),
		.bwd_count   (bwd_count),
		.pair_rd     (pair_rd)
	);

	tndq_accum u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.source_region (item.source_region),
		.target_region (item.target_region),
		.pair_rd       (pair_rd),
		.tab_rdata     (tab_rdata),
		.tab_raddr     (tab_raddr),
		.pipe_busy     (pipe_busy),
		.result        (result)
	);

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (item.cmd == tndq_pkg::CMD_QUERY) |=> busy)
		else $error("query transfer did not raise busy");

	a_other_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (item.cmd != tndq_pkg::CMD_QUERY) |=> !busy && !result_strobe)
		else $error("non-query transfer started a query");

	a_strobe_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy ##1 !busy)
		else $error("result strobe not on the last busy cycle");

	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.found |-> result.shortest == tndq_pkg::DIST_INF)
		else $error("shortest changed without an admitted pair");

endmodule
`default_nettype wire

### dv/transit_node_distance_query_unit_tb.sv
// Self-checking testbench for the transit-node distance query unit.
// Depends on hdl/tndq_pkg.sv and hdl/transit_node_distance_query_unit.sv; keeps its own
// shadow of the table, the node map and both access lists to predict each query answer.
`default_nettype none
module transit_node_distance_query_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tndq_pkg::*;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [DIST_W-1:0] span;
		logic [FLAG_W-1:0] flags;
	} access_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_t item = '0;
	out_t result;
	logic result_strobe;

	transit_node_distance_query_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result(result),
		.result_strobe(result_strobe)
	);

	always #5 clk = ~clk;

	// commands waiting to be driven, and query answers still owed by the block
	in_t cmd_backlog [$];
	out_t routes_due [$];
	int errors = 0;
	int idle_pct = 12;
	bit took = 1'b0;

	// shadow of the block state
	logic [DIST_W-1:0] tab_mem [TAB_DEPTH];
	logic [TI_W-1:0] ti_mem [GRAPH_NODES];
	access_t fwd_list [MAX_ACCESS];
	access_t bwd_list [MAX_ACCESS];
	int fwd_cnt = 0;
	int bwd_cnt = 0;

	// stimulus-side bookkeeping: what has been written, what the lists will hold
	int gen_ti [GRAPH_NODES];
	bit gen_tab [TAB_DEPTH];
	int gen_fwd [$];
	int gen_bwd [$];
	int real_items = 0;

	function automatic bit admits(logic [FLAG_W-1:0] flags, logic [REG_W-1:0] region);
		return (int'(region) < REGIONS) && flags[region];
	endfunction

	function automatic out_t best_route(logic [REG_W-1:0] sreg, logic [REG_W-1:0] treg);
		logic [SUM_W-1:0] best;
		logic [SUM_W-1:0] total;
		logic [DIST_W-1:0] tab;
		bit hit;
		out_t r;
		best = {2'b00, DIST_INF};
		hit = 1'b0;
		for (int i = 0; i < fwd_cnt; i++) begin
			if (admits(fwd_list[i].flags, treg)) begin
				for (int j = 0; j < bwd_cnt; j++) begin
					if (admits(bwd_list[j].flags, sreg)) begin
						tab = tab_mem[int'(ti_mem[fwd_list[i].node]) * TRANSIT_NODES
							+ int'(ti_mem[bwd_list[j].node])];
						if (tab != DIST_INF) begin
							hit = 1'b1;
							// form the sum wide so it cannot wrap
							total = SUM_W'(fwd_list[i].span) + SUM_W'(tab)
								+ SUM_W'(bwd_list[j].span);
							if (total < best)
								best = total;
						end
					end
				end
			end
		end
		r.shortest = best[DIST_W-1:0];
		r.found = hit;
		return r;
	endfunction

	task automatic apply_command(in_t it);
		case (it.cmd)
			CMD_TAB_WR: begin
				if (int'(it.row_index) < TRANSIT_NODES && int'(it.col_index) < TRANSIT_NODES)
					tab_mem[int'(it.row_index) * TRANSIT_NODES + int'(it.col_index)] = it.distance;
			end
			CMD_MAP_WR: begin
				if (int'(it.node_id) < GRAPH_NODES && int'(it.row_index) < TRANSIT_NODES)
					ti_mem[it.node_id] = it.row_index;
			end
			CMD_PUSH_FWD: begin
				if (int'(it.node_id) < GRAPH_NODES && fwd_cnt < MAX_ACCESS) begin
					fwd_list[fwd_cnt] = '{it.node_id, it.distance, it.region_flags};
					fwd_cnt++;
				end
			end
			CMD_PUSH_BWD: begin
				if (int'(it.node_id) < GRAPH_NODES && bwd_cnt < MAX_ACCESS) begin
					bwd_list[bwd_cnt] = '{it.node_id, it.distance, it.region_flags};
					bwd_cnt++;
				end
			end
			CMD_QUERY: begin
				routes_due.insert(routes_due.size(),
					best_route(it.source_region, it.target_region));
				fwd_cnt = 0;
				bwd_cnt = 0;
			end
			default: ;
		endcase
	endtask

	// Drive at the falling edge; hold an offered command until it transfers.
	always @(negedge clk) begin
		if (!(start && !took)) begin
			if (arst_n && cmd_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				item <= cmd_backlog.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		out_t want;
		took = arst_n && start && !busy;
		if (arst_n && result_strobe) begin
			if (routes_due.size() == 0) begin
				$error("result strobe with no query outstanding: shortest %h found %b",
					result.shortest, result.found);
				errors++;
			end else begin
				want = routes_due.pop_front();
				if (result.shortest !== want.shortest) begin
					$error("shortest: expected %h, got %h", want.shortest, result.shortest);
					errors++;
				end
				if (result.found !== want.found) begin
					$error("found: expected %b, got %b", want.found, result.found);
					errors++;
				end
			end
		end
		if (took)
			apply_command(item);
	end

	function automatic in_t rand_item();
		logic [127:0] r;
		r = {$urandom(), $urandom(), $urandom(), $urandom()};
		return r[$bits(in_t)-1:0];
	endfunction

	function automatic logic [DIST_W-1:0] pick_dist();
		case ($urandom_range(0, 7))
			0: return DIST_INF;
			1: return DIST_INF - DIST_W'($urandom_range(0, 15));
			2: return '0;
			3, 4: return $urandom();
			default: return DIST_W'($urandom_range(0, 1000));
		endcase
	endfunction

	function automatic logic [FLAG_W-1:0] pick_flags(int region);
		logic [FLAG_W-1:0] f;
		f = $urandom();
		case ($urandom_range(0, 9))
			0: f = '1;
			1: f = '0;
			2, 3: ;
			default: f[region] = 1'b1;
		endcase
		return f;
	endfunction

	function automatic int pick_ti();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, TRANSIT_NODES - 1)
			: $urandom_range(0, 7);
	endfunction

	function automatic int pick_len();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(MAX_ACCESS - 2, MAX_ACCESS + 4);
			default: return $urandom_range(1, 5);
		endcase
	endfunction

	task automatic emit(in_t it);
		cmd_backlog.insert(cmd_backlog.size(), it);
		if (it.cmd <= CMD_QUERY)
			real_items++;
	endtask

	task automatic write_map(int node, int ti);
		in_t it;
		it = rand_item();
		it.cmd = CMD_MAP_WR;
		it.node_id = NODE_W'(node);
		it.row_index = TI_W'(ti);
		gen_ti[node] = ti;
		emit(it);
	endtask

	task automatic write_table(int row, int col, logic [DIST_W-1:0] span);
		in_t it;
		it = rand_item();
		it.cmd = CMD_TAB_WR;
		it.row_index = TI_W'(row);
		it.col_index = TI_W'(col);
		it.distance = span;
		gen_tab[row * TRANSIT_NODES + col] = 1'b1;
		emit(it);
	endtask

	task automatic push_entry(bit fwd, int node, logic [DIST_W-1:0] span,
		logic [FLAG_W-1:0] flags);
		in_t it;
		it = rand_item();
		it.cmd = fwd ? CMD_PUSH_FWD : CMD_PUSH_BWD;
		it.node_id = NODE_W'(node);
		it.distance = span;
		it.region_flags = flags;
		emit(it);
		// entries past a full list are dropped by the block
		if (fwd && gen_fwd.size() < MAX_ACCESS)
			gen_fwd.insert(gen_fwd.size(), node);
		if (!fwd && gen_bwd.size() < MAX_ACCESS)
			gen_bwd.insert(gen_bwd.size(), node);
	endtask

	task automatic push_access(bit fwd, int region);
		int node;
		node = $urandom_range(0, GRAPH_NODES - 1);
		if (gen_ti[node] < 0 || $urandom_range(0, 7) == 0)
			write_map(node, pick_ti());
		push_entry(fwd, node, pick_dist(), pick_flags(region));
	endtask

	// Write readable table entries if unwritten or at random on refresh, then query.
	task automatic issue_query(int sreg, int treg, bit refresh);
		in_t it;
		int idx;
		foreach (gen_fwd[i]) begin
			foreach (gen_bwd[j]) begin
				idx = gen_ti[gen_fwd[i]] * TRANSIT_NODES + gen_ti[gen_bwd[j]];
				if (!gen_tab[idx] || (refresh && $urandom_range(0, 5) == 0))
					write_table(idx / TRANSIT_NODES, idx % TRANSIT_NODES, pick_dist());
			end
		end
		it = rand_item();
		it.cmd = CMD_QUERY;
		it.source_region = REG_W'(sreg);
		it.target_region = REG_W'(treg);
		emit(it);
		gen_fwd.delete();
		gen_bwd.delete();
	endtask

	task automatic noise();
		in_t it;
		it = rand_item();
		case ($urandom_range(0, 4))
			0: begin
				it.cmd = CMD_TAB_WR;
				gen_tab[int'(it.row_index) * TRANSIT_NODES + int'(it.col_index)] = 1'b1;
				emit(it);
			end
			1: begin
				it.cmd = CMD_MAP_WR;
				gen_ti[it.node_id] = int'(it.row_index);
				emit(it);
			end
			2: begin
				it.cmd = 3'(int'(CMD_QUERY) + $urandom_range(1, 3));
				emit(it);
			end
			default: push_access($urandom_range(0, 1), $urandom_range(0, REGIONS - 1));
		endcase
	endtask

	task automatic run_random(int upto);
		int sreg;
		int treg;
		int nf;
		int nb;
		int n;
		while (real_items < upto) begin
			sreg = $urandom_range(0, REGIONS - 1);
			treg = $urandom_range(0, REGIONS - 1);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					nf = pick_len();
					nb = pick_len();
					while (nf + nb > 0) begin
						if (nb == 0 || (nf != 0 && $urandom_range(0, 1) == 1)) begin
							push_access(1'b1, treg);
							nf--;
						end else begin
							push_access(1'b0, sreg);
							nb--;
						end
					end
					issue_query(sreg, treg, 1'b1);
				end
				6, 7: begin
					n = $urandom_range(1, 4);
					repeat (n) noise();
				end
				// leave a half-built list for whatever comes next
				8: begin
					n = $urandom_range(1, 3);
					repeat (n) push_access($urandom_range(0, 1), $urandom_range(0, REGIONS - 1));
				end
				default: issue_query(sreg, treg, 1'b1);
			endcase
		end
	endtask

	task automatic drain();
		while (cmd_backlog.size() != 0 || start || routes_due.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		in_t it;
		foreach (gen_ti[i]) gen_ti[i] = -1;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		write_map(0, 0);
		write_map(GRAPH_NODES - 1, TRANSIT_NODES - 1);
		write_table(0, TRANSIT_NODES - 1, 5);
		write_table(0, 0, DIST_INF - 1);
		write_table(TRANSIT_NODES - 1, 0, DIST_INF);
		// plain hit through the corner transit nodes
		push_entry(1'b1, 0, 0, '1);
		push_entry(1'b0, GRAPH_NODES - 1, 0, '1);
		issue_query(0, REGIONS - 1, 1'b0);
		// admitted pair whose sum overflows: found, shortest stays all ones
		push_entry(1'b1, 0, DIST_INF, 32'h8000_0000);
		push_entry(1'b0, 0, DIST_INF, 32'h0000_0001);
		issue_query(0, REGIONS - 1, 1'b0);
		// both lists empty
		issue_query(REGIONS - 1, 0, 1'b0);
		// table entry marks the pair unreachable
		push_entry(1'b1, GRAPH_NODES - 1, 7, '1);
		push_entry(1'b0, 0, 9, '1);
		issue_query(17, 3, 1'b0);
		// forward flags reject the target region
		push_entry(1'b1, 0, 1, 32'h0000_FFFF);
		push_entry(1'b0, GRAPH_NODES - 1, 2, '1);
		issue_query(5, 20, 1'b0);
		// backward list empty
		push_entry(1'b1, GRAPH_NODES - 1, 3, '1);
		issue_query(0, 0, 1'b0);
		for (int c = int'(CMD_QUERY) + 1; c < 8; c++) begin
			it = rand_item();
			it.cmd = 3'(c);
			emit(it);
		end

		run_random(real_items + 185);
		// hold off until every owed answer has come back
		drain();
		idle_pct = 69;
		run_random(real_items + 185);
		drain();
		idle_pct = 0;
		run_random(real_items + 185);
		drain();
		repeat (MAX_ACCESS * MAX_ACCESS + MAX_ACCESS + 16) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
